// File: rtl/nca_pkg.sv
// ----------------------------------------------------------------------------
// nca_pkg
// Shared sizes, codes and types of the nearest-centroid assigner.
// ----------------------------------------------------------------------------
package nca_pkg;

	// store geometry and number formats
	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_DIMS     = 16;
	localparam int COORD_BITS   = 16;

	localparam int CIDX_W  = $clog2(MAX_CLUSTERS);
	localparam int DIDX_W  = $clog2(MAX_DIMS);
	localparam int NC_W    = $clog2(MAX_CLUSTERS + 1);
	localparam int ND_W    = $clog2(MAX_DIMS + 1);
	localparam int ADDR_W  = CIDX_W + DIDX_W;
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int SQ_W    = 2 * COORD_BITS;
	localparam int DIST_W  = SQ_W + DIDX_W;

	// field widths fixed by the interface
	localparam int CMD_W   = 2;
	localparam int CFG_W   = 5;
	localparam int CNT_W   = 24;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POINT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START = 2'd2;

	// configuration register indexes
	localparam logic CFG_NUM_CLUSTERS = 1'b0;
	localparam logic CFG_NUM_DIMS     = 1'b1;

	typedef enum logic [1:0] {
		K_LOAD,
		K_POINT,
		K_START,
		K_NOP
	} kind_t;

	// classified item in the queue
	typedef struct packed {
		kind_t                  kind;
		logic [CIDX_W-1:0]      cidx;
		logic [DIDX_W-1:0]      didx;
		logic [COORD_BITS-1:0]  coord;
		logic [CIDX_W-1:0]      prev;
	} item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/nca_in_if.sv
// ----------------------------------------------------------------------------
// nca_in_if
// Input channel: command items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nca_in_if;
	import nca_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic [CIDX_W-1:0]       centroid_index;
	logic [DIDX_W-1:0]       dim_index;
	logic signed [COORD_BITS-1:0] coordinate;
	logic [CIDX_W-1:0]       previous_label;

	modport source (
		output valid, command, centroid_index, dim_index, coordinate, previous_label,
		input  ready
	);
	modport sink (
		input  valid, command, centroid_index, dim_index, coordinate, previous_label,
		output ready
	);
endinterface

// File: rtl/nca_out_if.sv
// ----------------------------------------------------------------------------
// nca_out_if
// Output channel: one assignment result per finished point.
// ----------------------------------------------------------------------------
interface nca_out_if;
	import nca_pkg::*;

	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] label;
	logic              label_changed;
	logic [CNT_W-1:0]  label_count;
	logic              pass_changed;

	modport source (
		output valid, label, label_changed, label_count, pass_changed,
		input  ready
	);
	modport sink (
		input  valid, label, label_changed, label_count, pass_changed,
		output ready
	);
endinterface

// File: rtl/nca_front.sv
// ----------------------------------------------------------------------------
// nca_front
// Accepts input items, decodes the command and queues them for the back end.
// ----------------------------------------------------------------------------
module nca_front (
	input  logic            clk,
	input  logic            arst_n,
	nca_in_if.sink          in_ch,
	output logic            q_valid,
	output nca_pkg::item_t  q_item,
	input  logic            q_pop
);
	import nca_pkg::*;

	item_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	item_t             item_in;
	logic              push;
	logic              pop;

	// classify the incoming command
	always_comb begin
		item_in.cidx  = in_ch.centroid_index;
		item_in.didx  = in_ch.dim_index;
		item_in.coord = in_ch.coordinate;
		item_in.prev  = in_ch.previous_label;
		case (in_ch.command)
			CMD_LOAD:  item_in.kind = K_LOAD;
			CMD_POINT: item_in.kind = K_POINT;
			CMD_START: item_in.kind = K_START;
			default:   item_in.kind = K_NOP;
		endcase
	end

	assign in_ch.ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != '0);
	assign pop         = q_pop && q_valid;
	assign q_item      = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/nca_back.sv
// ----------------------------------------------------------------------------
// nca_back
// Executes queued items: centroid store, shared multiply-accumulate scan over
// the active clusters, nearest pick, per-pass counts and the result register.
// ----------------------------------------------------------------------------
module nca_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_index,
	input  logic [nca_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        q_valid,
	input  nca_pkg::item_t              q_item,
	output logic                        q_pop,
	nca_out_if.source                   out_ch
);
	import nca_pkg::*;

	// configuration
	logic [CFG_W-1:0] num_clusters_q;
	logic [CFG_W-1:0] num_dims_q;
	logic [NC_W-1:0]  nc_eff;
	logic [ND_W-1:0]  nd_eff;

	// control
	state_t            state_q;
	state_t            state_d;
	logic [CIDX_W-1:0] clu_q;
	logic [DIDX_W-1:0] dim_q;
	logic              scan_last;
	logic              issue;
	logic              drain_done;
	logic              emit;
	logic              out_free;
	logic              clear_point;
	logic              start_pass;
	logic              load_wr;

	// current point coordinate
	logic [COORD_BITS-1:0] coord_q;
	logic [CIDX_W-1:0]     prev_q;
	logic                  last_q;

	// centroid store
	logic [COORD_BITS-1:0] store_mem [MAX_CLUSTERS*MAX_DIMS];

	// scan pipeline
	logic                     valid_s1;
	logic [CIDX_W-1:0]        clu_s1;
	logic [COORD_BITS-1:0]    cent_s1;
	logic                     valid_s2;
	logic [CIDX_W-1:0]        clu_s2;
	logic [SQ_W-1:0]          sq_s2;
	logic signed [DIFF_W-1:0] diff;
	logic signed [2*DIFF_W-1:0] prod;
	logic [DIST_W-1:0]        sum;

	// distances, nearest pick, statistics
	logic [DIST_W-1:0] dist_q  [MAX_CLUSTERS];
	logic [CNT_W-1:0]  count_q [MAX_CLUSTERS];
	logic [DIST_W-1:0] best_d_q;
	logic [CIDX_W-1:0] best_q;
	logic              pass_flag_q;
	logic              changed;
	logic [CNT_W-1:0]  count_next;

	// result register
	logic              out_valid_q;
	logic [CIDX_W-1:0] label_q;
	logic              label_changed_q;
	logic [CNT_W-1:0]  label_count_q;
	logic              pass_changed_q;

	// configuration registers saturated into range
	always_comb begin
		if (num_clusters_q == '0) begin
			nc_eff = NC_W'(1);
		end else if (NC_W'(num_clusters_q) > NC_W'(MAX_CLUSTERS)) begin
			nc_eff = NC_W'(MAX_CLUSTERS);
		end else begin
			nc_eff = NC_W'(num_clusters_q);
		end
		if (num_dims_q == '0) begin
			nd_eff = ND_W'(1);
		end else if (ND_W'(num_dims_q) > ND_W'(MAX_DIMS)) begin
			nd_eff = ND_W'(MAX_DIMS);
		end else begin
			nd_eff = ND_W'(num_dims_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= CFG_W'(MAX_CLUSTERS);
			num_dims_q     <= CFG_W'(MAX_DIMS);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_NUM_CLUSTERS: num_clusters_q <= cfg_wdata;
				CFG_NUM_DIMS:     num_dims_q     <= cfg_wdata;
				default:          num_clusters_q <= num_clusters_q;
			endcase
		end
	end

	assign scan_last = ((NC_W'(clu_q) + NC_W'(1)) == nc_eff);
	assign out_free  = !out_valid_q || out_ch.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && (q_item.kind == K_POINT)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!valid_s1 && !valid_s2) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop      = 1'b0;
		issue      = 1'b0;
		drain_done = 1'b0;
		emit       = 1'b0;
		case (state_q)
			ST_IDLE:  q_pop      = q_valid;
			ST_SCAN:  issue      = 1'b1;
			ST_DRAIN: drain_done = !valid_s1 && !valid_s2;
			ST_EMIT:  emit       = out_free;
			default:  q_pop      = 1'b0;
		endcase
	end

	assign start_pass  = q_pop && (q_item.kind == K_START);
	assign load_wr     = q_pop && (q_item.kind == K_LOAD);
	assign clear_point = start_pass || emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// cluster and dimension counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clu_q <= '0;
			dim_q <= '0;
		end else begin
			if (issue) begin
				clu_q <= scan_last ? '0 : clu_q + 1'b1;
			end
			if (clear_point) begin
				dim_q <= '0;
			end else if (drain_done && !last_q) begin
				dim_q <= dim_q + 1'b1;
			end
		end
	end

	// latch the point coordinate when it leaves the queue
	always_ff @(posedge clk) begin
		if (q_pop && (q_item.kind == K_POINT)) begin
			coord_q <= q_item.coord;
			prev_q  <= q_item.prev;
			last_q  <= ((ND_W'(dim_q) + ND_W'(1)) >= nd_eff);
		end
	end

	// centroid store: load writes, scan reads with registered data
	always_ff @(posedge clk) begin
		if (load_wr) begin
			store_mem[{q_item.cidx, q_item.didx}] <= q_item.coord;
		end
		if (issue) begin
			cent_s1 <= store_mem[{clu_q, dim_q}];
		end
	end

	// squared difference
	assign diff = $signed({coord_q[COORD_BITS-1], coord_q})
		- $signed({cent_s1[COORD_BITS-1], cent_s1});
	assign prod = (2*DIFF_W)'(diff) * (2*DIFF_W)'(diff);

	always_ff @(posedge clk) begin
		clu_s1 <= clu_q;
		clu_s2 <= clu_s1;
		sq_s2  <= prod[SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	// accumulate and track the nearest cluster, ties to the higher index
	assign sum = dist_q[clu_s2] + DIST_W'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				dist_q[i] <= '0;
			end
		end else if (clear_point) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				dist_q[i] <= '0;
			end
		end else if (valid_s2) begin
			dist_q[clu_s2] <= sum;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && last_q && ((clu_s2 == '0) || (sum <= best_d_q))) begin
			best_d_q <= sum;
			best_q   <= clu_s2;
		end
	end

	// per-pass statistics
	assign changed    = (best_q != prev_q);
	assign count_next = (count_q[best_q] == CNT_MAX) ? CNT_MAX : count_q[best_q] + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				count_q[i] <= '0;
			end
			pass_flag_q <= 1'b0;
		end else if (start_pass) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				count_q[i] <= '0;
			end
			pass_flag_q <= 1'b0;
		end else if (emit) begin
			count_q[best_q] <= count_next;
			pass_flag_q     <= pass_flag_q | changed;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			label_q         <= best_q;
			label_changed_q <= changed;
			label_count_q   <= count_next;
			pass_changed_q  <= pass_flag_q | changed;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.label         = label_q;
	assign out_ch.label_changed = label_changed_q;
	assign out_ch.label_count   = label_count_q;
	assign out_ch.pass_changed  = pass_changed_q;

endmodule

// File: rtl/nearest_centroid_assigner_core.sv
// An item first waits in the queue; load, start-pass and unused commands are then
// executed in the back end as they are popped from the queue.
// A point coordinate is scanned by the single shared multiply-accumulate, which
// visits one cluster per cycle and drains before the next item is popped; a point's
// last coordinate then loads the result register, once a held result is taken.
// Reset clears control, distances, counts and the pass flag; the store is undefined.
// ----------------------------------------------------------------------------
// nearest_centroid_assigner_core
// K-means assignment: front end queues classified items, back end scans
// centroid distances and reports the nearest cluster per point.
// ----------------------------------------------------------------------------
module nearest_centroid_assigner_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic                      cfg_index,
	input  logic [nca_pkg::CFG_W-1:0] cfg_wdata,
	nca_in_if.sink                    in_ch,
	nca_out_if.source                 out_ch
);
	import nca_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	// accept and classify
	nca_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// execute
	nca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_ch    (out_ch)
	);

endmodule

// File: rtl/nca_checker.sv
// ----------------------------------------------------------------------------
// nca_checker
// Port-level checks of the assigner's result channel.
// ----------------------------------------------------------------------------
module nca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  label,
	input logic        label_changed,
	input logic [23:0] label_count,
	input logic        pass_changed
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(label) && $stable(label_count))
		else $error("result changed while stalled");

	// a changed label marks the pass as changed
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && label_changed |-> pass_changed)
		else $error("label change not reflected in pass flag");

	// the count includes the point being reported
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> label_count != 24'd0)
		else $error("zero count on a result");

	// no result right after reset release
	assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind nearest_centroid_assigner_core nca_checker u_nca_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.label         (out_ch.label),
	.label_changed (out_ch.label_changed),
	.label_count   (out_ch.label_count),
	.pass_changed  (out_ch.pass_changed)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-centroid assigner. A directed table
// covers coordinate extremes, ties, pass starts, unused commands and
// register corner values. Random traffic follows under several register
// settings and flow-control mixes. Every result is compared with an
// in-bench distance model or, for checked table rows, a typed-in result.
// ----------------------------------------------------------------------------
module testbench;
	import nca_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned NUM_PHASES   = 12;
	localparam int unsigned PHASE_ITEMS  = 40;

	// one input transfer and one assignment result
	typedef struct packed {
		logic [CMD_W-1:0]      command;
		logic [CIDX_W-1:0]     cidx;
		logic [DIDX_W-1:0]     didx;
		logic [COORD_BITS-1:0] coord;
		logic [CIDX_W-1:0]     prev;
	} assign_req_t;

	typedef struct packed {
		logic [CIDX_W-1:0] label;
		logic              changed;
		logic [CNT_W-1:0]  count;
		logic              pass_flag;
	} assign_res_t;

	// directed table rows: register write, item checked by the model,
	// or item with its result typed in
	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_ITEM,
		ROW_CHECKED
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic                  reg_index;
		logic [CFG_W-1:0]      reg_value;
		logic [CMD_W-1:0]      command;
		logic [CIDX_W-1:0]     cidx;
		logic [DIDX_W-1:0]     didx;
		logic [COORD_BITS-1:0] coord;
		logic [CIDX_W-1:0]     prev;
		logic [CIDX_W-1:0]     label;
		logic                  changed;
		logic [CNT_W-1:0]      count;
		logic                  pass_flag;
	} step_row_t;

	localparam step_row_t DIRECTED [28] = '{
		// two clusters, one dimension, centroids at both coordinate extremes
		'{ROW_CFG,     CFG_NUM_CLUSTERS, 5'd2, CMD_LOAD,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_CFG,     CFG_NUM_DIMS,     5'd1, CMD_LOAD,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_LOAD,   4'd0, 4'd0, 16'h7FFF, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_LOAD,   4'd1, 4'd0, 16'h8000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_CHECKED, 1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h7FFF, 4'd0,
			4'd0, 1'b0, 24'd1, 1'b0},
		'{ROW_CHECKED, 1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h8000, 4'd0,
			4'd1, 1'b1, 24'd1, 1'b1},
		'{ROW_CHECKED, 1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd2, 1'b1},
		// equal distances go to the higher index
		'{ROW_ITEM,    1'b0, 5'd0, CMD_LOAD,   4'd0, 4'd0, 16'h0064, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_LOAD,   4'd1, 4'd0, 16'hFF9C, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_CHECKED, 1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h0000, 4'd1,
			4'd1, 1'b0, 24'd2, 1'b1},
		// unused command with every field bit set
		'{ROW_ITEM,    1'b0, 5'd0, CMD_UNUSED, 4'hF, 4'hF, 16'hFFFF, 4'hF,
			4'd0, 1'b0, 24'd0, 1'b0},
		// new pass clears counts and the sticky flag
		'{ROW_ITEM,    1'b0, 5'd0, CMD_START,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_CHECKED, 1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h0064, 4'd1,
			4'd0, 1'b1, 24'd1, 1'b1},
		'{ROW_CHECKED, 1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'hFF9C, 4'd1,
			4'd1, 1'b0, 24'd1, 1'b1},
		// two dimensions, new pass in the middle of a point
		'{ROW_CFG,     CFG_NUM_DIMS,     5'd2, CMD_LOAD,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_LOAD,   4'd0, 4'd1, 16'h1000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_LOAD,   4'd1, 4'd1, 16'hF000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h7FFF, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_START,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h0064, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_CHECKED, 1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h1000, 4'd0,
			4'd0, 1'b0, 24'd1, 1'b0},
		// zero clusters acts as one
		'{ROW_CFG,     CFG_NUM_CLUSTERS, 5'd0, CMD_LOAD,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h8000, 4'd3,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_CHECKED, 1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h7FFF, 4'd3,
			4'd0, 1'b1, 24'd2, 1'b1},
		// registers changed while a point is half received
		'{ROW_ITEM,    1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_CFG,     CFG_NUM_CLUSTERS, 5'd2, CMD_LOAD,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_CFG,     CFG_NUM_DIMS,     5'd1, CMD_LOAD,  4'd0, 4'd0, 16'h0000, 4'd0,
			4'd0, 1'b0, 24'd0, 1'b0},
		'{ROW_ITEM,    1'b0, 5'd0, CMD_POINT,  4'd0, 4'd0, 16'h1000, 4'd1,
			4'd0, 1'b0, 24'd0, 1'b0}
	};

	// flow-control mixes and register settings of the random phases
	localparam int unsigned SEND_IDLE_PCT [4] = '{0, 85, 0, 32};
	localparam int unsigned RECV_STALL_PCT [4] = '{0, 0, 85, 32};
	localparam logic [CFG_W-1:0] PHASE_CLUSTERS [NUM_PHASES] =
		'{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd8, 5'd3, 5'd12, 5'd2, 5'd16, 5'd9};
	localparam logic [CFG_W-1:0] PHASE_DIMS [NUM_PHASES] =
		'{5'd16, 5'd1, 5'd2, 5'd3, 5'd4, 5'd1, 5'd17, 5'd0, 5'd6, 5'd2, 5'd3, 5'd5};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	nca_in_if  in_ch ();
	nca_out_if out_ch ();

	nearest_centroid_assigner_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// distance model state
	logic signed [COORD_BITS-1:0] centroids [MAX_CLUSTERS][MAX_DIMS];
	logic [DIST_W-1:0] distances [MAX_CLUSTERS];
	logic [CNT_W-1:0]  label_counts [MAX_CLUSTERS];
	int unsigned       coords_seen;
	logic              any_changed;
	logic [CFG_W-1:0]  clusters_reg;
	logic [CFG_W-1:0]  dims_reg;

	assign_res_t pending_results [$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned cycle_count;
	int unsigned n_errors;
	int unsigned n_items;
	int unsigned n_results;
	int unsigned n_settings;

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		assign_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation: label %0d count %0d", out_ch.label,
					out_ch.label_count);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				n_results++;
				if (out_ch.label !== want.label) begin
					$error("label: expected %0d, actual %0d", want.label, out_ch.label);
					n_errors++;
				end
				if (out_ch.label_changed !== want.changed) begin
					$error("label_changed: expected %0d, actual %0d", want.changed,
						out_ch.label_changed);
					n_errors++;
				end
				if (out_ch.label_count !== want.count) begin
					$error("label_count: expected %0d, actual %0d", want.count,
						out_ch.label_count);
					n_errors++;
				end
				if (out_ch.pass_changed !== want.pass_flag) begin
					$error("pass_changed: expected %0d, actual %0d", want.pass_flag,
						out_ch.pass_changed);
					n_errors++;
				end
			end
		end
	end

	function automatic int unsigned clamp_reg(input logic [CFG_W-1:0] v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return 32'(v);
	endfunction

	// apply one item to the model; returns 1 when a point completes
	function automatic bit assign_point(input assign_req_t req, output assign_res_t res);
		int unsigned nc;
		int unsigned nd;
		int unsigned best;
		logic [DIST_W-1:0] best_d;
		logic signed [DIFF_W-1:0] diff;
		logic [DIFF_W-1:0] mag;
		logic [SQ_W-1:0] sq;
		nc = clamp_reg(clusters_reg, MAX_CLUSTERS);
		nd = clamp_reg(dims_reg, MAX_DIMS);
		res = '0;
		case (req.command)
			CMD_LOAD: begin
				centroids[req.cidx][req.didx] = req.coord;
				return 1'b0;
			end
			CMD_START: begin
				foreach (label_counts[c])
					label_counts[c] = '0;
				any_changed = 1'b0;
				foreach (distances[c])
					distances[c] = '0;
				coords_seen = 0;
				return 1'b0;
			end
			CMD_POINT: begin
				// accumulate squared difference for every active centroid
				if (coords_seen < MAX_DIMS) begin
					for (int c = 0; c < nc; c++) begin
						diff = DIFF_W'($signed(req.coord)) - DIFF_W'(centroids[c][coords_seen]);
						mag = (diff < 0) ? -diff : diff;
						sq = SQ_W'(mag) * SQ_W'(mag);
						distances[c] = distances[c] + DIST_W'(sq);
					end
				end
				coords_seen++;
				if (coords_seen < nd)
					return 1'b0;
				// nearest centroid, ties to the higher index
				best = 0;
				best_d = distances[0];
				for (int c = 1; c < nc; c++) begin
					if (distances[c] <= best_d) begin
						best_d = distances[c];
						best = c;
					end
				end
				res.label = CIDX_W'(best);
				res.changed = (res.label != req.prev);
				if (label_counts[best] != CNT_MAX)
					label_counts[best]++;
				any_changed = any_changed | res.changed;
				res.count = label_counts[best];
				res.pass_flag = any_changed;
				foreach (distances[c])
					distances[c] = '0;
				coords_seen = 0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			// coarse grid values make equal distances likely
			2: return COORD_BITS'($urandom_range(15) << 12);
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic assign_req_t rand_req();
		assign_req_t req;
		req.command = CMD_W'($urandom);
		req.cidx = CIDX_W'($urandom);
		req.didx = DIDX_W'($urandom);
		req.coord = rand_coord();
		req.prev = CIDX_W'($urandom);
		return req;
	endfunction

	// drive one transfer; called and returning at a falling edge
	task automatic send_item(input assign_req_t req, input bit use_typed,
		input assign_res_t typed);
		assign_res_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= req.command;
		in_ch.centroid_index <= req.cidx;
		in_ch.dim_index <= req.didx;
		in_ch.coordinate <= req.coord;
		in_ch.previous_label <= req.prev;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		n_items++;
		if (assign_point(req, res))
			pending_results.push_back(use_typed ? typed : res);
		@(negedge clk);
	endtask

	// hold off until every result is back and the block has settled
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic set_register(input logic idx, input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_NUM_CLUSTERS)
			clusters_reg = value;
		else
			dims_reg = value;
		n_settings++;
	endtask

	// stimulus
	initial begin
		step_row_t row;
		assign_req_t req;
		assign_res_t typed;
		int unsigned pick;
		int unsigned sent;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_LOAD;
		in_ch.centroid_index = '0;
		in_ch.dim_index = '0;
		in_ch.coordinate = '0;
		in_ch.previous_label = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycle_count = 0;
		n_errors = 0;
		n_items = 0;
		n_results = 0;
		n_settings = 0;

		// model reset
		foreach (centroids[c, d])
			centroids[c][d] = '0;
		foreach (distances[c])
			distances[c] = '0;
		foreach (label_counts[c])
			label_counts[c] = '0;
		coords_seen = 0;
		any_changed = 1'b0;
		clusters_reg = CFG_W'(MAX_CLUSTERS);
		dims_reg = CFG_W'(MAX_DIMS);

		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CFG) begin
				set_register(row.reg_index, row.reg_value);
			end else begin
				req.command = row.command;
				req.cidx = row.cidx;
				req.didx = row.didx;
				req.coord = row.coord;
				req.prev = row.prev;
				typed.label = row.label;
				typed.changed = row.changed;
				typed.count = row.count;
				typed.pass_flag = row.pass_flag;
				send_item(req, row.kind == ROW_CHECKED, typed);
			end
		end

		// fill the whole centroid store so every point reads defined entries
		for (int c = 0; c < MAX_CLUSTERS; c++) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				req = rand_req();
				req.command = CMD_LOAD;
				req.cidx = CIDX_W'(c);
				req.didx = DIDX_W'(d);
				send_item(req, 1'b0, '0);
			end
		end

		// random phases: mostly point streams, some loads, pass starts and noise
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_register(CFG_NUM_CLUSTERS, PHASE_CLUSTERS[ph]);
			set_register(CFG_NUM_DIMS, PHASE_DIMS[ph]);
			send_idle_pct = SEND_IDLE_PCT[ph % 4];
			recv_stall_pct = RECV_STALL_PCT[ph % 4];
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				req = rand_req();
				if (pick >= 97) begin
					wait_idle();
					continue;
				end
				if (pick < 80)
					req.command = CMD_POINT;
				else if (pick < 88)
					req.command = CMD_LOAD;
				else if (pick < 93)
					req.command = CMD_START;
				else
					req.command = CMD_UNUSED;
				send_item(req, 1'b0, '0);
				if (req.command != CMD_UNUSED)
					sent++;
			end
		end

		// drain and report
		send_idle_pct = 0;
		wait_idle();
		$display("run covered %0d item transfers and %0d checked results", n_items,
			n_results);
		$display("over %0d register writes and four flow-control mixes", n_settings);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
